// File: hdl/crs_pkg.sv
// ----------------------------------------------------------------------------
// crs_pkg: shared types for the column range to row span converter
// Field widths, row bound arithmetic, the walk plan and the cell control group.
// ----------------------------------------------------------------------------
package crs_pkg;

  localparam int COL_BITS = 11;
  localparam int ROW_BITS = 6;
  localparam int BND_W    = 8;
  localparam int ROWS_DEF = 64;

  typedef logic [COL_BITS-1:0]     col_t;
  typedef logic [ROW_BITS-1:0]     row_t;
  typedef logic signed [BND_W-1:0] bnd_t;

  // stand-ins for "no rows": above every row, below every row
  localparam bnd_t NONE_TOP    = 8'sd127;
  localparam bnd_t NONE_BOTTOM = -8'sd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_TOP,
    ST_BOT
  } crs_state_t;

  // closing walks (t: top part, b: bottom part) and opening ranges (o1, o2)
  typedef struct packed {
    logic t_do;
    bnd_t t_lo;
    bnd_t t_hi;
    logic b_do;
    bnd_t b_hi;
    bnd_t b_lo;
    logic o1_do;
    bnd_t o1_lo;
    bnd_t o1_hi;
    logic o2_do;
    bnd_t o2_lo;
    bnd_t o2_hi;
  } crs_plan_t;

  typedef struct packed {
    logic rot_fwd;   // every cell takes its upper neighbor, head row goes up
    logic rot_back;  // every cell takes its lower neighbor, head row goes down
    logic write;     // cells in an opening range record here, the column less one
  } crs_ctl_t;

  function automatic bnd_t bnd_min(input bnd_t a, input bnd_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic bnd_t bnd_max(input bnd_t a, input bnd_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

// File: hdl/crs_decode.sv
// ----------------------------------------------------------------------------
// crs_decode: range comparison for one column
// Works out which rows close (top part, bottom part) and which rows open.
// ----------------------------------------------------------------------------
module crs_decode (
  input  crs_pkg::row_t      prev_top,
  input  crs_pkg::row_t      prev_bottom,
  input  logic               prev_valid,
  input  crs_pkg::row_t      top_row,
  input  crs_pkg::row_t      bottom_row,
  input  logic               column_empty,
  output crs_pkg::crs_plan_t plan
);
  import crs_pkg::*;

  bnd_t s0, e0, s1, e1;
  bnd_t t_hi, s0n, b_lo, e0n, o1_hi, s1n, o2_lo;
  logic t_do, b_do, o1_do;

  always_comb begin
    s0 = prev_valid ? $signed(BND_W'(prev_top)) : NONE_TOP;
    e0 = prev_valid ? $signed(BND_W'(prev_bottom)) : NONE_BOTTOM;
    s1 = column_empty ? NONE_TOP : $signed(BND_W'(top_row));
    e1 = column_empty ? NONE_BOTTOM : $signed(BND_W'(bottom_row));

    // rows cut off at the top, walked downward
    t_hi = bnd_min(e0, s1 - bnd_t'(1));
    t_do = (s0 <= t_hi);
    s0n  = t_do ? t_hi + bnd_t'(1) : s0;

    // rows cut off at the bottom, walked upward
    b_lo = bnd_max(e1 + bnd_t'(1), s0n);
    b_do = (e0 >= b_lo);
    e0n  = b_do ? b_lo - bnd_t'(1) : e0;

    // newly covered rows above and below what is left of the old range
    o1_hi = bnd_min(s0n - bnd_t'(1), e1);
    o1_do = (s1 <= o1_hi);
    s1n   = o1_do ? o1_hi + bnd_t'(1) : s1;
    o2_lo = bnd_max(e0n + bnd_t'(1), s1n);

    plan.t_do  = t_do;
    plan.t_lo  = s0;
    plan.t_hi  = t_hi;
    plan.b_do  = b_do;
    plan.b_hi  = e0;
    plan.b_lo  = b_lo;
    plan.o1_do = o1_do;
    plan.o1_lo = s1;
    plan.o1_hi = o1_hi;
    plan.o2_do = (e1 >= o2_lo);
    plan.o2_lo = o2_lo;
    plan.o2_hi = e1;
  end

endmodule

// File: hdl/crs_cell.sv
// ----------------------------------------------------------------------------
// crs_cell: one cell of the row ring
// Holds a row tag and that row's opening column; shifts either way around
// the ring or records the current column less one when its row opens.
// ----------------------------------------------------------------------------
module crs_cell #(
  parameter int ROW_W = 6,
  parameter int INDEX = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  crs_pkg::crs_ctl_t  ctl,
  input  crs_pkg::crs_plan_t plan,
  input  crs_pkg::col_t      here,
  input  logic [ROW_W-1:0]   up_tag,
  input  crs_pkg::col_t      up_col,
  input  logic [ROW_W-1:0]   down_tag,
  input  crs_pkg::col_t      down_col,
  output logic [ROW_W-1:0]   tag,
  output crs_pkg::col_t      col
);
  import crs_pkg::*;

  localparam int CMPW = (ROW_W + 1 > BND_W) ? ROW_W + 1 : BND_W;

  logic signed [CMPW-1:0] tag_s;
  logic                   hit;

  always_comb begin
    tag_s = $signed(CMPW'(tag));
    hit   = (plan.o1_do && tag_s >= CMPW'(plan.o1_lo) && tag_s <= CMPW'(plan.o1_hi)) ||
            (plan.o2_do && tag_s >= CMPW'(plan.o2_lo) && tag_s <= CMPW'(plan.o2_hi));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag <= ROW_W'(INDEX);
    end else if (ctl.rot_fwd) begin
      tag <= up_tag;
    end else if (ctl.rot_back) begin
      tag <= down_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rot_fwd) begin
      col <= up_col;
    end else if (ctl.rot_back) begin
      col <= down_col;
    end else if (ctl.write && hit) begin
      col <= here;
    end
  end

endmodule

// File: hdl/column_ranges_to_row_spans.sv
// ----------------------------------------------------------------------------
// column_ranges_to_row_spans: column row ranges to horizontal row spans
// Ring of row cells holding each row's opening column, walked by a sequencer.
// ----------------------------------------------------------------------------
// Usage
//   s_* carries one column per transfer, left to right; a plane is ended by
//   sending an empty column. m_* carries one closed span per transfer, top
//   part of the closed rows first (downward), then the bottom part (upward);
//   m_tlast marks the last span caused by a column.
//   A column is taken, then written, then walked: the ring moves as needed to
//   bring the first closing row of each part to the head cell; the ring
//   rotates one row per cycle and emits while rotating, so within a part the
//   spans leave back to back unless the receiver stalls. Adjacent columns
//   usually close rows near where the last one stopped, so the seek is short.
//   Rows newly covered are recorded for all cells at once, in the write state.
//   s_tready is high only between columns. A finished span sits in the output
//   register; the next column is taken while it waits, and a stalled receiver
//   holds the walk without losing a span.
//   Reset (synchronous) empties the output register, marks the previous
//   column empty and sets the ring in row order; opening columns are only
//   meaningful once written.
// ----------------------------------------------------------------------------
module column_ranges_to_row_spans #(
  parameter int ROWS = crs_pkg::ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // column[10:0], top_row[16:11], bottom_row[22:17], zero
  input  logic [1:0]  s_tuser,   // column_empty[0], plane_start[1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // span_row[5:0], span_first[16:6], span_stop[27:17], zero
  output logic        m_tlast    // last_span
);
  import crs_pkg::*;

  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = (ROW_W > ROW_BITS) ? ROW_W : ROW_BITS;

  crs_state_t state, state_next;
  crs_plan_t  plan, plan_w;
  crs_ctl_t   ctl;
  col_t       here;
  row_t       prev_top, prev_bottom;
  logic       prev_empty;
  row_t       cur_row, cur_next;

  logic [ROW_W-1:0] tag_w [ROWS];
  col_t             col_w [ROWS];

  col_t in_column;
  row_t in_top, in_bottom;
  logic in_empty, in_start;

  logic          slot_free, at_head, cur_oor, emit, emit_last;
  logic [CW-1:0] head_ext, cur_ext;
  row_t          span_row;
  col_t          span_first;
  logic          span_last;

  assign in_column = s_tdata[10:0];
  assign in_top    = s_tdata[16:11];
  assign in_bottom = s_tdata[22:17];
  assign in_empty  = s_tuser[0];
  assign in_start  = s_tuser[1];

  assign s_tready = (state == ST_IDLE);

  crs_decode u_decode (
    .prev_top     (prev_top),
    .prev_bottom  (prev_bottom),
    .prev_valid   (!in_start && !prev_empty),
    .top_row      (in_top),
    .bottom_row   (in_bottom),
    .column_empty (in_empty),
    .plan         (plan_w)
  );

  for (genvar i = 0; i < ROWS; i++) begin : g_cell
    crs_cell #(
      .ROW_W (ROW_W),
      .INDEX (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .plan     (plan),
      .here     (here),
      .up_tag   (tag_w[(i + 1) % ROWS]),
      .up_col   (col_w[(i + 1) % ROWS]),
      .down_tag (tag_w[(i + ROWS - 1) % ROWS]),
      .down_col (col_w[(i + ROWS - 1) % ROWS]),
      .tag      (tag_w[i]),
      .col      (col_w[i])
    );
  end

  always_comb begin
    slot_free = !m_tvalid || m_tready;
    head_ext  = CW'(tag_w[0]);
    cur_ext   = CW'(cur_row);
    at_head   = (head_ext == cur_ext);
    // rows past the ring are never stored and read as column zero
    cur_oor   = (32'(cur_row) >= ROWS);
  end

  always_comb begin
    state_next = state;
    cur_next   = cur_row;
    ctl        = '0;
    emit       = 1'b0;
    emit_last  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        ctl.write = 1'b1;
        if (plan.t_do) begin
          state_next = ST_TOP;
          cur_next   = row_t'(plan.t_lo);
        end else if (plan.b_do) begin
          state_next = ST_BOT;
          cur_next   = row_t'(plan.b_hi);
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_TOP: begin
        if (cur_oor || at_head) begin
          if (slot_free) begin
            emit        = 1'b1;
            ctl.rot_fwd = !cur_oor;
            if (cur_row == row_t'(plan.t_hi)) begin
              emit_last = !plan.b_do;
              if (plan.b_do) begin
                state_next = ST_BOT;
                cur_next   = row_t'(plan.b_hi);
              end else begin
                state_next = ST_IDLE;
              end
            end else begin
              cur_next = cur_row + row_t'(1);
            end
          end
        end else if (cur_ext > head_ext) begin
          ctl.rot_fwd = 1'b1;
        end else begin
          ctl.rot_back = 1'b1;
        end
      end
      ST_BOT: begin
        if (cur_oor || at_head) begin
          if (slot_free) begin
            emit         = 1'b1;
            ctl.rot_back = !cur_oor;
            if (cur_row == row_t'(plan.b_lo)) begin
              emit_last  = 1'b1;
              state_next = ST_IDLE;
            end else begin
              cur_next = cur_row - row_t'(1);
            end
          end
        end else if (cur_ext > head_ext) begin
          ctl.rot_fwd = 1'b1;
        end else begin
          ctl.rot_back = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      prev_empty  <= 1'b1;
      prev_top    <= '0;
      prev_bottom <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (s_tvalid && s_tready) begin
        prev_top    <= in_top;
        prev_bottom <= in_bottom;
        prev_empty  <= in_empty;
      end
      if (slot_free) begin
        m_tvalid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_row <= cur_next;
    if (s_tvalid && s_tready) begin
      plan <= plan_w;
      here <= in_column - col_t'(1);
    end
    if (emit) begin
      span_row   <= cur_row;
      span_first <= cur_oor ? '0 : col_w[0];
      span_last  <= emit_last;
    end
  end

  // span_stop is the column of the walk less one, held steady until the next span is emitted
  logic [10:0] span_stop;
  always_ff @(posedge clk) begin
    if (emit) begin
      span_stop <= here;
    end
  end

  assign m_tdata = {4'b0, span_stop, span_first, span_row};
  assign m_tlast = span_last;

endmodule

// File: hdl/crs_checker.sv
// ----------------------------------------------------------------------------
// crs_checker: port-level checks for the span converter
// Watches the stream ports for reset, stall and column sequencing behavior.
// ----------------------------------------------------------------------------
module crs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [23:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);

  // after reset the output is empty and a column can be taken
  a_reset_state: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("output not empty or input not ready after reset");

  // a stalled span holds its contents
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("span changed while stalled");

  // one column at a time: the input closes right after a transfer
  a_one_column: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second column taken while the first is still walked");

  // an empty column that starts a plane closes nothing and goes back to idle right after its write state
  a_empty_start: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser[0] && s_tuser[1]) |=> ##1 s_tready)
    else $error("empty plane-start column did not finish in two cycles");

endmodule

bind column_ranges_to_row_spans crs_checker u_crs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// File: bench/tb_column_ranges_to_row_spans.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_column_ranges_to_row_spans: self-checking bench for the span converter
// Feeds columns left to right: a directed table first, then random planes
// mixed with stray columns. Expected spans come from an in-bench predictor
// and are compared field by field in order. Runs through several idling
// phases, with a full drain between phases and a watchdog on stalls.
// ----------------------------------------------------------------------------
module tb_column_ranges_to_row_spans;
  import crs_pkg::*;

  localparam int ROWS           = 64;
  localparam int MAX_ROW        = ROWS - 1;
  localparam int MAX_COLUMN     = 1025;
  localparam int N_DIRECTED     = 21;
  localparam int RAND_PER_PHASE = 52;
  localparam int N_PHASES       = 5;
  localparam int STALL_LIMIT    = 5000;
  localparam int TAIL_CYCLES    = 200;

  typedef enum int {CHK_MODEL, CHK_NONE, CHK_ONE} chk_kind_t;

  typedef struct packed {
    row_t row;
    col_t first;
    col_t stop;
    logic last;
  } span_t;

  typedef struct {
    int        column;
    int        top;
    int        bottom;
    bit        empty;
    bit        fresh;
    chk_kind_t kind;
    int        e_row;
    int        e_first;
    int        e_stop;
  } column_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // column[10:0], top_row[16:11], bottom_row[22:17], zero
  logic [1:0]  s_tuser;   // column_empty[0], plane_start[1]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;   // span_row[5:0], span_first[16:6], span_stop[27:17], zero
  logic        m_tlast;   // last_span

  // predictor state
  col_t  open_col [ROWS];
  row_t  last_top;
  row_t  last_bottom;
  logic  last_empty;
  span_t exp_spans [$];

  int tx_idle  = 0;
  int rx_stall = 0;
  int errors   = 0;
  int columns_sent = 0;
  int quiet_cycles = 0;

  int phase_tx [N_PHASES] = '{0, 75, 0, 21, 0};
  int phase_rx [N_PHASES] = '{0, 0, 75, 21, 0};

  column_row_t col_table [N_DIRECTED] = '{
    // first column after reset opens row 0, closed by the empty column behind it
    '{1,    0,  0,  1'b0, 1'b0, CHK_NONE,  0,  0,    0},
    '{2,    0,  0,  1'b1, 1'b0, CHK_ONE,   0,  0,    1},
    // top column index, then column zero wraps the stop
    '{1025, 63, 63, 1'b0, 1'b1, CHK_NONE,  0,  0,    0},
    '{0,    0,  0,  1'b1, 1'b0, CHK_ONE,   63, 1024, 2047},
    '{0,    0,  63, 1'b0, 1'b1, CHK_NONE,  0,  0,    0},
    '{1025, 0,  63, 1'b0, 1'b0, CHK_NONE,  0,  0,    0},
    '{1024, 1,  62, 1'b0, 1'b0, CHK_MODEL, 0,  0,    0},
    '{3,    0,  0,  1'b1, 1'b0, CHK_MODEL, 0,  0,    0},
    // inverted range covers nothing but is kept as the previous bounds
    '{10,   40, 10, 1'b0, 1'b1, CHK_NONE,  0,  0,    0},
    '{11,   20, 30, 1'b0, 1'b0, CHK_NONE,  0,  0,    0},
    '{12,   25, 35, 1'b0, 1'b0, CHK_MODEL, 0,  0,    0},
    '{13,   0,  63, 1'b0, 1'b1, CHK_NONE,  0,  0,    0},
    '{14,   30, 31, 1'b0, 1'b0, CHK_MODEL, 0,  0,    0},
    '{15,   10, 5,  1'b0, 1'b0, CHK_MODEL, 0,  0,    0},
    '{16,   5,  5,  1'b0, 1'b0, CHK_NONE,  0,  0,    0},
    '{17,   5,  5,  1'b1, 1'b1, CHK_NONE,  0,  0,    0},
    '{18,   7,  7,  1'b0, 1'b0, CHK_NONE,  0,  0,    0},
    '{18,   7,  7,  1'b0, 1'b0, CHK_NONE,  0,  0,    0},
    // going backwards gives a span with first past stop
    '{17,   8,  8,  1'b0, 1'b0, CHK_ONE,   7,  17,   16},
    '{20,   0,  0,  1'b1, 1'b0, CHK_ONE,   8,  16,   19},
    '{21,   0,  0,  1'b1, 1'b0, CHK_NONE,  0,  0,    0}
  };

  column_ranges_to_row_spans dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // queues the spans closed by one column and updates the row bookkeeping
  function automatic int predict_spans(input col_t column, input int top, input int bottom,
                                       input bit empty, input bit fresh);
    int   s0, e0, s1, e1, n;
    col_t here;
    here = column - 1'b1;
    n = 0;
    if (fresh || last_empty) begin
      s0 = int'(NONE_TOP);
      e0 = int'(NONE_BOTTOM);
    end else begin
      s0 = int'(last_top);
      e0 = int'(last_bottom);
    end
    if (empty) begin
      s1 = int'(NONE_TOP);
      e1 = int'(NONE_BOTTOM);
    end else begin
      s1 = top;
      e1 = bottom;
    end
    // rows cut off at the top, walking down
    while (s0 < s1 && s0 <= e0) begin
      exp_spans.push_back('{row_t'(s0), open_col[s0], here, 1'b0});
      n++;
      s0++;
    end
    // rows cut off at the bottom, walking up
    while (e0 > e1 && e0 >= s0) begin
      exp_spans.push_back('{row_t'(e0), open_col[e0], here, 1'b0});
      n++;
      e0--;
    end
    while (s1 < s0 && s1 <= e1) begin
      open_col[s1] = here;
      s1++;
    end
    while (e1 > e0 && e1 >= s1) begin
      open_col[e1] = here;
      e1--;
    end
    if (n > 0) exp_spans[exp_spans.size()-1].last = 1'b1;
    last_top    = row_t'(top);
    last_bottom = row_t'(bottom);
    last_empty  = empty;
    return n;
  endfunction

  function automatic int clamp_row(input int r);
    if (r < 0) return 0;
    if (r > MAX_ROW) return MAX_ROW;
    return r;
  endfunction

  task automatic send_column(input int column, input int top, input int bottom,
                             input bit empty, input bit fresh, output int n_spans);
    while ($urandom_range(0, 99) < tx_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, row_t'(bottom), row_t'(top), col_t'(column)};
    s_tuser  <= {fresh, empty};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_spans = predict_spans(col_t'(column), top, bottom, empty, fresh);
    columns_sent++;
  endtask

  // a run of adjacent columns with a drifting range, closed by an empty column
  task automatic send_plane();
    int len, base, top, bottom, n;
    len    = $urandom_range(1, 12);
    base   = $urandom_range(0, MAX_COLUMN - len);
    top    = $urandom_range(0, MAX_ROW);
    bottom = $urandom_range(top, MAX_ROW);
    for (int i = 0; i < len; i++) begin
      send_column(base + i, top, bottom, 1'b0, i == 0, n);
      if ($urandom_range(0, 7) == 0) begin
        top    = $urandom_range(0, MAX_ROW);
        bottom = $urandom_range(0, MAX_ROW);
      end else begin
        top    = clamp_row(top + int'($urandom_range(0, 6)) - 3);
        bottom = clamp_row(bottom + int'($urandom_range(0, 6)) - 3);
      end
    end
    send_column(base + len, $urandom_range(0, MAX_ROW), $urandom_range(0, MAX_ROW),
                1'b1, 1'b0, n);
  endtask

  task automatic wait_drained();
    while (exp_spans.size() != 0) @(posedge clk);
  endtask

  // output side: random stalls, in-order compare
  always @(posedge clk) begin
    span_t got, want;
    if (m_tvalid && m_tready) begin
      got = '{m_tdata[5:0], m_tdata[16:6], m_tdata[27:17], m_tlast};
      if (exp_spans.size() == 0) begin
        $display("%0t: span with none expected: row %0d first %0d stop %0d last %0b",
                 $time, got.row, got.first, got.stop, got.last);
        errors++;
      end else begin
        want = exp_spans.pop_front();
        if (got !== want) begin
          $display("%0t: span mismatch: expected row %0d first %0d stop %0d last %0b,",
                   $time, want.row, want.first, want.stop, want.last);
          $display("%0t:                actual   row %0d first %0d stop %0d last %0b",
                   $time, got.row, got.first, got.stop, got.last);
          errors++;
        end
      end
    end
    m_tready <= ($urandom_range(0, 99) >= rx_stall);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int n;
    column_row_t r;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    last_top    = '0;
    last_bottom = '0;
    last_empty  = 1'b1;
    foreach (open_col[i]) open_col[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (col_table[i]) begin
      r = col_table[i];
      send_column(r.column, r.top, r.bottom, r.empty, r.fresh, n);
      if (r.kind != CHK_MODEL) begin
        repeat (n) void'(exp_spans.pop_back());
        if (r.kind == CHK_ONE)
          exp_spans.push_back('{row_t'(r.e_row), col_t'(r.e_first), col_t'(r.e_stop), 1'b1});
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      // hold the sender until every span so far is out
      s_tvalid <= 1'b0;
      wait_drained();
      tx_idle  = phase_tx[ph];
      rx_stall = phase_rx[ph];
      while (columns_sent < N_DIRECTED + (ph + 1) * RAND_PER_PHASE) begin
        if ($urandom_range(0, 4) == 0)
          send_column($urandom_range(0, MAX_COLUMN), $urandom_range(0, MAX_ROW),
                      $urandom_range(0, MAX_ROW), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), n);
        else
          send_plane();
      end
    end

    s_tvalid <= 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
